// File: rtl/report_by_exception_can_publisher_macros.svh
// Assertion macros used by the checker file rtl/rbe_checker.sv.
`ifndef REPORT_BY_EXCEPTION_CAN_PUBLISHER_MACROS_SVH
`define REPORT_BY_EXCEPTION_CAN_PUBLISHER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define RBE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rbe_pkg.sv
`default_nettype none
package rbe_pkg;
    localparam int NumVars      = 13;
    localparam int IdxW         = 4;
    localparam int VarW         = $clog2(NumVars);
    localparam int FirstWordVar = 4;
    localparam int FirstFltVar  = 5;
    localparam int QDepth       = 2;

    typedef enum logic {
        FUNC_UPDATE  = 1'b0,
        FUNC_REQUEST = 1'b1
    } func_t;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        logic            is_upd;
        logic [VarW-1:0] var_n;
        logic [31:0]     value;
        logic            force_send;
    } cmd_t;

    function automatic logic [31:0] width_mask(input logic [VarW-1:0] n);
        if (n < VarW'(FirstWordVar)) begin
            return 32'h0000_00FF;
        end else if (n < VarW'(FirstFltVar)) begin
            return 32'h0000_FFFF;
        end
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [2:0] var_bytes(input logic [VarW-1:0] n);
        if (n < VarW'(FirstWordVar)) begin
            return 3'd1;
        end else if (n < VarW'(FirstFltVar)) begin
            return 3'd2;
        end
        return 3'd4;
    endfunction
endpackage
`default_nettype wire

// File: rtl/rbe_front.sv
`default_nettype none
module rbe_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [10:0]             base_id,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    in_func,
    input  wire logic [3:0]              in_idx,
    input  wire logic [31:0]             in_value,
    input  wire logic                    in_force,
    input  wire logic [10:0]             in_req,
    output logic                         q_valid,
    input  wire logic                    q_ready,
    output rbe_pkg::cmd_t                q_cmd
);
    localparam int CntW = $clog2(rbe_pkg::QDepth + 1);

    rbe_pkg::cmd_t   fifo_reg [rbe_pkg::QDepth];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    rbe_pkg::cmd_t   cmd;
    logic            keep;
    logic [10:0]     diff;
    logic            push, pop;

    // The request offset from base_id gives the lowest matching variable directly.
    always_comb begin
        diff           = in_req - base_id;
        cmd.force_send = in_force;
        if (in_func == rbe_pkg::FUNC_UPDATE) begin
            cmd.is_upd = 1'b1;
            cmd.var_n  = in_idx[rbe_pkg::VarW-1:0];
            cmd.value  = in_value & rbe_pkg::width_mask(in_idx[rbe_pkg::VarW-1:0]);
            keep       = in_idx < 4'(rbe_pkg::NumVars);
        end else begin
            cmd.is_upd = 1'b0;
            cmd.var_n  = diff[rbe_pkg::VarW-1:0];
            cmd.value  = in_value;
            keep       = diff < 11'(rbe_pkg::NumVars);
        end
    end

    assign in_ready = cnt_reg != CntW'(rbe_pkg::QDepth);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = cnt_reg != '0;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + CntW'(push) - CntW'(pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/rbe_fcmp.sv
`default_nettype none
// Decides whether float cur lies outside [0.8, 1.2] times last, exactly.
// With l = m*2^e, 1.2*l = 6m*2^e/5, so c <= 1.2l is 5c <= 6l and c >= 0.8l
// is 5c >= 4l, with all terms as integer mantissas aligned on exponents.
module rbe_fcmp (
    input  wire logic [31:0] cur,
    input  wire logic [31:0] last,
    output logic             changed
);
    logic        cs, ls, cnan, lnan, cinf, linf;
    logic [7:0]  ce, le;
    logic [23:0] cm, lm;
    logic [26:0] c5;
    logic [26:0] l6, l4;
    logic [8:0]  ediff;
    logic        c_zero, l_zero;
    logic        le_hi, ge_lo;
    logic [4:0]  sh;

    always_comb begin
        cs     = cur[31];
        ls     = last[31];
        ce     = cur[30:23];
        le     = last[30:23];
        cnan   = (ce == 8'hFF) && (cur[22:0] != '0);
        lnan   = (le == 8'hFF) && (last[22:0] != '0);
        cinf   = (ce == 8'hFF) && (cur[22:0] == '0);
        linf   = (le == 8'hFF) && (last[22:0] == '0);
        cm     = {ce != 8'd0, cur[22:0]};
        lm     = {le != 8'd0, last[22:0]};
        c_zero = cur[30:0] == '0;
        l_zero = last[30:0] == '0;
        c5     = 27'(cm) * 27'd5;
        l6     = 27'(lm) * 27'd6;
        l4     = 27'(lm) * 27'd4;
        // effective exponents (denormals use 1)
        ediff  = 9'({1'b0, (ce == 8'd0) ? 8'd1 : ce}) - 9'({1'b0, (le == 8'd0) ? 8'd1 : le});
        sh     = 5'd0;
        le_hi  = 1'b0;
        ge_lo  = 1'b0;
        if (l_zero) begin
            le_hi = c_zero;
            ge_lo = c_zero;
        end else if (c_zero || cs) begin
            le_hi = 1'b1;
            ge_lo = c_zero ? 1'b0 : 1'b0;
        end else if (ediff[8]) begin
            // cur exponent smaller: cur below 0.8*last unless close
            if (ediff > 9'h1E7) begin
                sh    = 5'(-ediff);
                le_hi = 1'b1;
                ge_lo = (c5 >> sh) >= l4;
            end else begin
                le_hi = 1'b1;
                ge_lo = 1'b0;
            end
        end else begin
            if (ediff < 9'd8) begin
                sh    = 5'(ediff);
                ge_lo = (ediff != 9'd0) || (c5 >= l4);
                le_hi = (l6 >> sh) >= c5;
            end else begin
                ge_lo = 1'b1;
                le_hi = 1'b0;
            end
        end
        // An infinity on either side is inside the band only against the
        // same infinity. A negative nonzero last value leaves an empty band.
        changed = cnan || lnan
                  || ((cinf || linf) ? (cur != last)
                                     : ((ls && !l_zero) || !(le_hi && ge_lo)));
    end
endmodule
`default_nettype wire

// File: rtl/rbe_back.sv
`default_nettype none
module rbe_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [10:0]   base_id,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire rbe_pkg::cmd_t q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [10:0]        m_id,
    output logic [2:0]         m_cnt,
    output logic [31:0]        m_payload
);
    localparam int N = rbe_pkg::NumVars;
    localparam int W = rbe_pkg::VarW;

    logic [31:0]  cur_reg  [N];
    logic [31:0]  last_reg [N];
    logic         out_v_reg;
    logic [10:0]  id_reg;
    logic [2:0]   cnt_reg;
    logic [31:0]  pay_reg;
    logic [31:0]  cur_v, last_v, val;
    logic         fchg, chg, send;

    assign cur_v  = cur_reg[q_cmd.var_n];
    assign last_v = last_reg[q_cmd.var_n];
    assign val    = q_cmd.is_upd ? q_cmd.value : cur_v;

    rbe_fcmp u_fcmp (.cur(val), .last(last_v), .changed(fchg));

    always_comb begin
        if (q_cmd.var_n < W'(rbe_pkg::FirstFltVar)) begin
            chg = val != last_v;
        end else begin
            chg = fchg;
        end
        send = !q_cmd.is_upd || q_cmd.force_send || chg;
    end

    assign q_ready   = !out_v_reg || m_ready;
    assign m_valid   = out_v_reg;
    assign m_id      = id_reg;
    assign m_cnt     = cnt_reg;
    assign m_payload = pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            for (int i = 0; i < N; i++) begin
                cur_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            if (q_valid && q_ready) begin
                cur_reg[q_cmd.var_n] <= val;
                if (send) begin
                    last_reg[q_cmd.var_n] <= val;
                    out_v_reg             <= 1'b1;
                    id_reg  <= base_id + 11'(q_cmd.var_n);
                    cnt_reg <= rbe_pkg::var_bytes(q_cmd.var_n);
                    pay_reg <= val;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/report_by_exception_can_publisher.sv
`default_nettype none
// Channel   | Direction | Contents
// s_axis    | in        | tdata {request_id, force_send, new_value, var_index}, tuser func
// m_axis    | out       | tdata {payload, byte_count, frame_id}
// apb       | in        | base_id at byte address 0
//
// An item passes the combinational front classifier into a two-entry queue;
// the back part handles one queued item per cycle unless the output register
// holds a stalled result, so with an empty queue a result passes the queue
// and then the output register, and items sustain one per cycle at best.
// Reset is synchronous, active low, and clears both value tables at once.
// Either side may stall; the queue and the output register absorb it.
module report_by_exception_can_publisher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // var_index[3:0], new_value[35:4], force_send[36], request_id[47:37]
    input  wire logic [47:0] s_tdata,
    // func[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // frame_id[10:0], byte_count[13:11], payload[45:14], zero [47:46]
    output logic [47:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [10:0]   base_id_reg;
    logic          q_valid, q_ready;
    rbe_pkg::cmd_t q_cmd;
    logic [10:0]   m_id;
    logic [2:0]    m_cnt;
    logic [31:0]   m_pay;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, base_id_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_id_reg <= '0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            base_id_reg <= pwdata[10:0];
        end
    end

    rbe_front u_front (
        .aclk(aclk), .aresetn(aresetn), .base_id(base_id_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_func(s_tuser),
        .in_idx(s_tdata[3:0]), .in_value(s_tdata[35:4]), .in_force(s_tdata[36]),
        .in_req(s_tdata[47:37]), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    rbe_back u_back (
        .aclk(aclk), .aresetn(aresetn), .base_id(base_id_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_id(m_id), .m_cnt(m_cnt), .m_payload(m_pay)
    );

    assign m_tdata = {2'b00, m_pay, m_cnt, m_id};
endmodule
`default_nettype wire

// File: rtl/rbe_checker.sv
`default_nettype none
`include "report_by_exception_can_publisher_macros.svh"
module rbe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        pready
);
    `RBE_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")
    `RBE_ASSERT_IMPL(a_cnt, aclk, aresetn, m_tvalid, m_tdata[13:11] == 3'd1 || m_tdata[13:11] == 3'd2 || m_tdata[13:11] == 3'd4, "bad byte count")
    `RBE_ASSERT_IMPL(a_byte, aclk, aresetn, m_tvalid && m_tdata[13:11] == 3'd1, m_tdata[45:22] == 24'd0, "byte payload too wide")
    `RBE_ASSERT_IMPL(a_rdy, aclk, aresetn, 1'b1, pready, "pready low")
endmodule

bind report_by_exception_can_publisher rbe_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire

// File: tb/rbe_frame_checker.sv
`default_nettype none
// Watches the item channel and the APB port, predicts the data frames that
// the publisher must emit, and compares them with the result channel.
module rbe_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               frames_pending
);
    localparam logic [1:0] BaseIdAddr = 2'd0;

    typedef struct {
        logic [10:0] frame_id;
        logic [2:0]  byte_count;
        logic [31:0] payload;
    } can_frame_t;

    can_frame_t  expected_frames[$];
    logic [31:0] cur_val[rbe_pkg::NumVars];
    logic [31:0] sent_val[rbe_pkg::NumVars];
    logic [10:0] base_id;
    int          mismatches;

    function automatic real float_bits_value(input logic [31:0] b);
        real mag;
        int  e;
        e = int'(b[30:23]);
        if (e == 255) begin
            mag = 1.0e300;  // infinity; far above any finite single
        end else if (e == 0) begin
            mag = real'(b[22:0]) * (2.0 ** -149);
        end else begin
            mag = (1.0 + real'(b[22:0]) / 8388608.0) * (2.0 ** (e - 127));
        end
        return b[31] ? -mag : mag;
    endfunction

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] var_mask(input int n);
        if (n < rbe_pkg::FirstWordVar) return 32'h0000_00FF;
        if (n < rbe_pkg::FirstFltVar) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    // Bytes and words change on any difference; floats only outside the
    // band from 0.8 to 1.2 times the last value sent, with NaN always sent.
    // An infinity stays inside the band only against the same infinity.
    function automatic logic value_moved(input int n);
        real c;
        real l;
        if (n < rbe_pkg::FirstFltVar) return cur_val[n] != sent_val[n];
        if (is_nan(cur_val[n]) || is_nan(sent_val[n])) return 1'b1;
        if (is_inf(cur_val[n]) || is_inf(sent_val[n])) return cur_val[n] != sent_val[n];
        c = float_bits_value(cur_val[n]);
        l = float_bits_value(sent_val[n]);
        return !((c <= l * 1.2) && (c >= l * 0.8));
    endfunction

    task automatic publish(input int n);
        can_frame_t f;
        sent_val[n] = cur_val[n];
        f.frame_id = base_id + 11'(n);
        f.byte_count = (n < rbe_pkg::FirstWordVar) ? 3'd1
                     : (n < rbe_pkg::FirstFltVar) ? 3'd2 : 3'd4;
        f.payload = cur_val[n] & var_mask(n);
        expected_frames.push_back(f);
    endtask

    task automatic predict_frame(input logic [47:0] d, input logic fn);
        int          idx;
        logic [10:0] req;
        idx = int'(d[3:0]);
        req = d[47:37];
        if (rbe_pkg::func_t'(fn) == rbe_pkg::FUNC_UPDATE) begin
            if (idx < rbe_pkg::NumVars) begin
                cur_val[idx] = d[35:4] & var_mask(idx);
                if (d[36] || value_moved(idx)) publish(idx);
            end
        end else begin
            // The lowest matching variable wins when identifiers wrap.
            for (int n = 0; n < rbe_pkg::NumVars; n++) begin
                if (11'(base_id + 11'(n)) == req) begin
                    publish(n);
                    break;
                end
            end
        end
    endtask

    task automatic check_frame(input logic [47:0] d);
        can_frame_t e;
        if (expected_frames.size() == 0) begin
            fail_count++;
            if (mismatches++ < 10) $display("unexpected frame %h", d);
            return;
        end
        e = expected_frames.pop_front();
        if (d[10:0] !== e.frame_id || d[13:11] !== e.byte_count
                || d[45:14] !== e.payload || d[47:46] !== 2'b00) begin
            fail_count++;
            if (mismatches++ < 10) begin
                $display("frame mismatch: expected id %h len %0d data %h",
                         e.frame_id, e.byte_count, e.payload);
                $display("                got id %h len %0d data %h",
                         d[10:0], d[13:11], d[45:14]);
            end
        end
    endtask

    initial begin
        fail_count = 0;
        mismatches = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < rbe_pkg::NumVars; n++) begin
                cur_val[n] = '0;
                sent_val[n] = '0;
            end
            base_id = '0;
            expected_frames.delete();
        end else begin
            if (m_tvalid && m_tready) check_frame(m_tdata);
            if (s_tvalid && s_tready) predict_frame(s_tdata, s_tuser);
            if (psel && penable && pwrite && pready && paddr == BaseIdAddr) begin
                base_id = pwdata[10:0];
            end
        end
        frames_pending = expected_frames.size();
    end
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
// Stimulus and verdict for the report-by-exception publisher. The checker
// beside the block does all prediction; this module makes traffic and reads its counts.
module tb;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // var_index[3:0], new_value[35:4], force_send[36], request_id[47:37]
    logic [47:0] s_tdata;
    // func[0]
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // frame_id[10:0], byte_count[13:11], payload[45:14], zero[47:46]
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          frames_pending;

    // Idle patterns are switched off in one phase to get back-to-back items.
    logic        quiet;
    int          ready_hold;
    // Last value the stimulus wrote to each variable, used to aim floats
    // near the deadband edges.
    logic [31:0] shadow_val[16];
    logic [10:0] cur_base;

    localparam logic [1:0] BaseIdAddr = 2'd0;

    report_by_exception_can_publisher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rbe_frame_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // The receiver holds each ready level for a random number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_hold <= 0;
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
            ready_hold <= pick_gap();
        end
    end

    // One item on the input channel; the sender may drop valid afterward.
    task automatic send_item(input logic fn, input logic [3:0] idx, input logic [31:0] val,
                             input logic frc, input logic [10:0] req);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {req, frc, val, idx};
        if (fn == rbe_pkg::FUNC_UPDATE) shadow_val[idx] = val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_base_id(input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BaseIdAddr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_base = val[10:0];
    endtask

    // Waits until the checker has seen every predicted frame come out. The
    // count is read at the falling edge, after the checker has updated it.
    task automatic wait_frames_out();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        @(negedge aclk);
        while (frames_pending != 0) @(negedge aclk);
    endtask

    // Lets the block drain: all predicted frames out, then a wait for
    // any item still inside that produces nothing.
    task automatic drain();
        wait_frames_out();
        repeat (8) @(posedge aclk);
    endtask

    // A float near the last one written: nudge the mantissa a little or a
    // lot, so the value lands on both sides of the deadband.
    function automatic logic [31:0] near_float(input logic [31:0] prev);
        logic [31:0] v;
        v = prev;
        case ($urandom_range(0, 3))
            0: v[15:0] = 16'($urandom);
            1: v[22:0] = 23'($urandom);
            2: v[22:19] = v[22:19] + 4'($urandom_range(1, 2));
            default: v[22:0] = v[22:0] - 23'($urandom_range(0, 1) << 20);
        endcase
        return v;
    endfunction

    task automatic random_item();
        int          r;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] junk;
        r = $urandom_range(0, 99);
        junk = $urandom;
        if (r < 72) begin
            idx = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
                0, 1, 2: val = $urandom;
                3: val = shadow_val[idx];
                4: begin
                    case ($urandom_range(0, 5))
                        0: val = 32'h0000_0000;
                        1: val = 32'h8000_0000;
                        2: val = 32'h7FC0_0000 | (32'($urandom) & 32'h003F_FFFF);
                        3: val = 32'h7F80_0000;
                        4: val = 32'hFF80_0000;
                        default: val = 32'hBF80_0000;
                    endcase
                end
                default: begin
                    if (idx < rbe_pkg::FirstFltVar) begin
                        val = shadow_val[idx] ^ (32'(1) << $urandom_range(0, 15))
                              ^ (32'($urandom) & 32'hFFFF_0000);
                    end else begin
                        val = near_float(shadow_val[idx]);
                    end
                end
            endcase
            send_item(rbe_pkg::FUNC_UPDATE, idx, val, ($urandom_range(0, 7) == 0), junk[10:0]);
        end else if (r < 94) begin
            send_item(rbe_pkg::FUNC_REQUEST, junk[3:0], $urandom, junk[4],
                      cur_base + 11'($urandom_range(0, 12)));
        end else begin
            send_item(rbe_pkg::FUNC_REQUEST, junk[3:0], $urandom, junk[4], 11'($urandom));
        end
    endtask

    initial begin
        #(12 * 1200000);
        $display("FAIL report_by_exception_can_publisher");
        $finish;
    end

    initial begin
        logic [31:0] bases[6];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        cur_base = '0;
        for (int i = 0; i < 16; i++) shadow_val[i] = '0;
        bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_07F8, 32'h0000_0400,
                  32'($urandom), 32'h0000_07F4};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with base identifier zero.
        write_base_id(32'h0);
        send_item(rbe_pkg::FUNC_UPDATE, 4'd0, 32'h0000_0000, 1'b0, 11'h7FF);  // unchanged byte
        send_item(rbe_pkg::FUNC_UPDATE, 4'd0, 32'hFFFF_FF00, 1'b0, 11'h000);  // upper bits ignored
        send_item(rbe_pkg::FUNC_UPDATE, 4'd3, 32'h0000_00FF, 1'b0, 11'h000);
        send_item(rbe_pkg::FUNC_UPDATE, 4'd3, 32'h0000_00FF, 1'b1, 11'h000);  // forced repeat
        send_item(rbe_pkg::FUNC_UPDATE, 4'd4, 32'hABCD_FFFF, 1'b0, 11'h000);
        send_item(rbe_pkg::FUNC_UPDATE, 4'd4, 32'h1234_FFFF, 1'b0, 11'h000);  // same word
        send_item(rbe_pkg::FUNC_UPDATE, 4'd5, 32'h8000_0000, 1'b0, 11'h000);  // minus zero
        send_item(rbe_pkg::FUNC_UPDATE, 4'd5, 32'h3F80_0000, 1'b0, 11'h000);  // 1.0 from zero
        send_item(rbe_pkg::FUNC_UPDATE, 4'd5, 32'h3F99_9999, 1'b0, 11'h000);  // inside band
        send_item(rbe_pkg::FUNC_UPDATE, 4'd5, 32'h3FA0_0000, 1'b0, 11'h000);  // above band
        send_item(rbe_pkg::FUNC_UPDATE, 4'd6, 32'hBF80_0000, 1'b0, 11'h000);  // negative
        send_item(rbe_pkg::FUNC_UPDATE, 4'd6, 32'hBF80_0000, 1'b0, 11'h000);  // negative last
        send_item(rbe_pkg::FUNC_UPDATE, 4'd7, 32'h7FC0_0000, 1'b0, 11'h000);  // NaN
        send_item(rbe_pkg::FUNC_UPDATE, 4'd7, 32'h7FC0_0000, 1'b0, 11'h000);
        send_item(rbe_pkg::FUNC_UPDATE, 4'd12, 32'h7F80_0000, 1'b0, 11'h000); // infinity
        send_item(rbe_pkg::FUNC_UPDATE, 4'd12, 32'h7F80_0000, 1'b0, 11'h000);
        send_item(rbe_pkg::FUNC_UPDATE, 4'd13, 32'hFFFF_FFFF, 1'b1, 11'h000); // out of range
        send_item(rbe_pkg::FUNC_UPDATE, 4'd15, 32'h1234_5678, 1'b1, 11'h000);
        send_item(rbe_pkg::FUNC_REQUEST, 4'd0, 32'h0, 1'b0, 11'd0);
        send_item(rbe_pkg::FUNC_REQUEST, 4'd0, 32'h0, 1'b0, 11'd12);
        send_item(rbe_pkg::FUNC_REQUEST, 4'hF, 32'hFFFF_FFFF, 1'b1, 11'd13);  // unmatched
        send_item(rbe_pkg::FUNC_REQUEST, 4'd0, 32'h0, 1'b0, 11'h7FF);         // unmatched
        drain();

        // Random phases, each under a base identifier from bases. Identifier wrap
        // shows up with the bases near the top of the range.
        for (int p = 0; p < 6; p++) begin
            write_base_id(bases[p]);
            quiet = (p == 2);
            for (int i = 0; i < 255; i++) begin
                random_item();
                // Hold the sender until every frame has come out.
                if (i == 120) begin
                    wait_frames_out();
                end
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("PASS report_by_exception_can_publisher");
        end else begin
            $display("FAIL report_by_exception_can_publisher");
        end
        $finish;
    end
endmodule
`default_nettype wire
